// ===== sv/b64d_pkg.sv =====
// Shared types, codes and character-class functions for the Base64 stream decoder.
package b64d_pkg;

  // Status codes carried on the last result of a message.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
  localparam logic [1:0] ERR_LENGTH   = 2'd2;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  // Depth of the group record queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One record: up to three compacted bytes plus end-of-message status.
  typedef struct packed {
    logic [2:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      last_idx;  // index of the final result of this record
    logic            valid;     // results carry decoded bytes
    logic            last;      // record ends a message
    logic [1:0]      err;       // status, meaningful when last is set
  } rec_t;

  // Queue status seen by both front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Whitespace: horizontal tab through carriage return, and space.
  function automatic logic is_space(input logic [7:0] c);
    return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
  endfunction

  // Returns {hit, sextet}; hit is low for a code outside the alphabet.
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if ((c >= 8'h41) && (c <= 8'h5A)) begin
      d = c - 8'd65;
      return {1'b1, d[5:0]};
    end else if ((c >= 8'h61) && (c <= 8'h7A)) begin
      d = c - 8'd71;
      return {1'b1, d[5:0]};
    end else if ((c >= 8'h30) && (c <= 8'h39)) begin
      d = c + 8'd4;
      return {1'b1, d[5:0]};
    end else if (c == 8'h2B) begin
      return {1'b1, 6'd62};
    end else if (c == 8'h2F) begin
      return {1'b1, 6'd63};
    end
    return 7'd0;
  endfunction

endpackage

// ===== sv/b64d_front.sv =====
// Front end: classifies characters, assembles groups and issues group records.
module b64d_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [7:0]          char_in,
  input  logic                end_of_message,
  input  b64d_pkg::q_status_t q_stat,
  output logic                full,
  output logic                rec_push,
  output b64d_pkg::rec_t      rec
);

  logic [17:0] group_bits, group_bits_next;
  logic [1:0]  group_position, group_position_next;
  logic        third_is_pad, third_is_pad_next;
  logic        content_started, content_started_next;
  logic        in_trailing_space, in_trailing_space_next;
  logic [1:0]  latched_error, latched_error_next;

  logic        accept;
  logic        space;
  logic        pad;
  logic [6:0]  sx;
  logic [5:0]  v;
  logic [23:0] triple;
  logic        complete;
  logic        emit;
  logic [1:0]  status;

  assign full   = q_stat.full;
  assign accept = push && !q_stat.full;

  // Character classification.
  assign space = b64d_pkg::is_space(char_in);
  assign pad   = (char_in == b64d_pkg::PAD_CHAR);
  assign sx    = b64d_pkg::sextet_of(char_in);
  assign v     = (pad || !sx[6]) ? 6'd0 : sx[5:0];

  assign complete = !space && (group_position == 2'd3);
  assign triple   = {group_bits, v};

  // Next state of the group assembler and the error latch.
  always_comb begin
    group_bits_next        = group_bits;
    group_position_next    = group_position;
    third_is_pad_next      = third_is_pad;
    content_started_next   = content_started;
    in_trailing_space_next = in_trailing_space;
    latched_error_next     = latched_error;
    if (space) begin
      if (content_started) begin
        in_trailing_space_next = 1'b1;
      end
    end else begin
      content_started_next = 1'b1;
      if ((in_trailing_space || (!pad && !sx[6])) && (latched_error == b64d_pkg::ERR_NONE)) begin
        latched_error_next = b64d_pkg::ERR_BAD_CHAR;
      end
      unique case (group_position)
        2'd0: begin
          group_bits_next     = {v, 12'd0};
          group_position_next = 2'd1;
        end
        2'd1: begin
          group_bits_next     = group_bits | {6'd0, v, 6'd0};
          group_position_next = 2'd2;
        end
        2'd2: begin
          group_bits_next     = group_bits | {12'd0, v};
          third_is_pad_next   = pad;
          group_position_next = 2'd3;
        end
        default: begin
          group_bits_next     = 18'd0;
          group_position_next = 2'd0;
          third_is_pad_next   = 1'b0;
        end
      endcase
    end
  end

  assign emit = complete && (latched_error_next == b64d_pkg::ERR_NONE);

  // End-of-message status: a latched error wins over a partial group.
  always_comb begin
    if (latched_error_next != b64d_pkg::ERR_NONE) begin
      status = latched_error_next;
    end else if (group_position_next != 2'd0) begin
      status = b64d_pkg::ERR_LENGTH;
    end else begin
      status = b64d_pkg::ERR_NONE;
    end
  end

  // Build the record with the emitted bytes packed to the front.
  always_comb begin
    rec.bytes    = '0;
    rec.last_idx = 2'd0;
    rec.valid    = emit;
    rec.last     = end_of_message;
    rec.err      = end_of_message ? status : b64d_pkg::ERR_NONE;
    if (emit) begin
      rec.bytes[0] = triple[23:16];
      if (!third_is_pad) begin
        rec.bytes[1] = triple[15:8];
        rec.bytes[2] = triple[7:0];
        rec.last_idx = pad ? 2'd1 : 2'd2;
      end else begin
        rec.bytes[1] = triple[7:0];
        rec.last_idx = pad ? 2'd0 : 2'd1;
      end
    end
  end

  assign rec_push = accept && (emit || end_of_message);

  // State registers; the end of a message returns everything to reset.
  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_message)) begin
      group_bits        <= 18'd0;
      group_position    <= 2'd0;
      third_is_pad      <= 1'b0;
      content_started   <= 1'b0;
      in_trailing_space <= 1'b0;
      latched_error     <= b64d_pkg::ERR_NONE;
    end else if (accept) begin
      group_bits        <= group_bits_next;
      group_position    <= group_position_next;
      third_is_pad      <= third_is_pad_next;
      content_started   <= content_started_next;
      in_trailing_space <= in_trailing_space_next;
      latched_error     <= latched_error_next;
    end
  end

endmodule

// ===== sv/b64d_queue.sv =====
// Small queue of group records between the front end and the output sequencer.
module b64d_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  b64d_pkg::rec_t      push_rec,
  input  logic                pop,
  output b64d_pkg::rec_t      head_rec,
  output b64d_pkg::q_status_t q_stat
);

  b64d_pkg::rec_t mem [b64d_pkg::QUEUE_DEPTH];

  logic [b64d_pkg::QPTR_W-1:0] wptr;
  logic [b64d_pkg::QPTR_W-1:0] rptr;
  logic [b64d_pkg::QCNT_W-1:0] count;
  logic                        do_push;
  logic                        do_pop;

  assign q_stat.full  = (count == b64d_pkg::QCNT_W'(b64d_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_rec     = mem[rptr];

  // Record storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= push_rec;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/b64d_back.sv =====
// Output sequencer: steps through the bytes of the head record one per transfer.
module b64d_back (
  input  logic                clk,
  input  logic                rst,
  input  b64d_pkg::rec_t      head_rec,
  input  b64d_pkg::q_status_t q_stat,
  input  logic                pop,
  output logic                q_pop,
  output logic                empty,
  output logic [7:0]          data_byte,
  output logic                byte_valid,
  output logic [1:0]          error_code,
  output logic                last
);

  logic [1:0] idx;
  logic       at_end;
  logic       take;

  assign empty  = q_stat.empty;
  assign take   = pop && !q_stat.empty;
  assign at_end = (idx == head_rec.last_idx);
  assign q_pop  = take && at_end;

  // Result fields come from the selected byte of the head record.
  always_comb begin
    unique case (idx)
      2'd0:    data_byte = head_rec.bytes[0];
      2'd1:    data_byte = head_rec.bytes[1];
      default: data_byte = head_rec.bytes[2];
    endcase
  end

  assign byte_valid = head_rec.valid;
  assign last       = at_end && head_rec.last;
  assign error_code = last ? head_rec.err : b64d_pkg::ERR_NONE;

  // Byte index within the head record.
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (take) begin
      idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

// ===== sv/base64_stream_decoder.sv =====
// Top level of the streaming Base64 decoder with front end, record queue and output sequencer.
//
// The decoder takes one character per cycle while full is low and hands out one result per
// cycle while pop is high and empty is low. The front end classifies each character and
// completes a group every fourth non-whitespace character, writing one record of up to three
// bytes (or an end-of-message status) into a four-entry record queue; the output sequencer
// then spends one transfer per byte of that record. A steady stream of groups runs at one
// character per cycle with no stall. full rises only when the record queue holds four records,
// which happens when the consumer stalls or when many very short messages arrive, since each
// message end costs one record. Bytes stream out before the message ends, so the consumer must
// drop the whole message when the last result carries a nonzero error_code.
module base64_stream_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_in,
  input  logic       end_of_message,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] data_byte,
  output logic       byte_valid,
  output logic [1:0] error_code,
  output logic       last
);

  b64d_pkg::rec_t      rec;
  b64d_pkg::rec_t      head_rec;
  b64d_pkg::q_status_t q_stat;
  logic                rec_push;
  logic                q_pop;

  b64d_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .char_in        (char_in),
    .end_of_message (end_of_message),
    .q_stat         (q_stat),
    .full           (full),
    .rec_push       (rec_push),
    .rec            (rec)
  );

  b64d_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (rec_push),
    .push_rec (rec),
    .pop      (q_pop),
    .head_rec (head_rec),
    .q_stat   (q_stat)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_rec   (head_rec),
    .q_stat     (q_stat),
    .pop        (pop),
    .q_pop      (q_pop),
    .empty      (empty),
    .data_byte  (data_byte),
    .byte_valid (byte_valid),
    .error_code (error_code),
    .last       (last)
  );

  // The queue can never report full and empty together.
  a_full_empty: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty))
    else $error("record queue reports full and empty at once");

  // A result without a byte is only ever the status marker at a message end.
  a_status_only: assert property (@(posedge clk) disable iff (rst)
    (!empty && !byte_valid) |-> (last && (data_byte == 8'd0)))
    else $error("result without a byte is not a last status marker");

  // A nonzero status appears only on the last result of a message.
  a_err_on_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && (error_code != b64d_pkg::ERR_NONE)) |-> last)
    else $error("error status shown on a result that is not last");

  // A record is written only for an accepted character.
  a_push_accept: assert property (@(posedge clk) disable iff (rst)
    rec_push |-> (push && !full))
    else $error("record written without a character transfer");

endmodule
